/* hw/rtl/esfs_pkg.sv */
package esfs_pkg;

    localparam int ENT_W = 18;
    localparam int LOG_W = 21;
    localparam logic [ENT_W-1:0] ENT_MAX = 18'h3FFFF;

    typedef struct packed {
        logic [7:0] feature_id;
        logic [4:0] attr_value;
        logic [2:0] class_label;
        logic       last_sample;
        logic       last_feature;
    } sample_t;

    typedef struct packed {
        logic [ENT_W-1:0] column_entropy;
        logic [7:0]       best_feature_id;
        logic [7:0]       best_position;
        logic [ENT_W-1:0] best_entropy;
        logic             selection_done;
        logic             overflow;
    } result_t;

    typedef struct packed {
        logic inc;
        logic pair_clr;
        logic val_clr;
    } hist_cmd_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_UPD,
        S_VRD,
        S_VWT,
        S_VLOG,
        S_PRD,
        S_PWT,
        S_PLOG,
        S_MUL,
        S_ACC,
        S_DIV,
        S_OUT
    } state_t;

endpackage

/* hw/rtl/esfs_hist.sv */
module esfs_hist
    import esfs_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int PA_W = 8,
    parameter int VA_W = 5,
    parameter int CELLS = 256,
    parameter int NVALS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hist_cmd_t        cmd,
    input  logic [PA_W-1:0]  pair_addr,
    input  logic [VA_W-1:0]  val_addr,
    output logic [CNT_W-1:0] pair_rd,
    output logic [CNT_W-1:0] val_rd
);

    logic [CNT_W-1:0] pair_mem [CELLS];
    logic [CNT_W-1:0] val_mem [NVALS];

    logic             inc_d_reg;
    logic [PA_W-1:0]  pa_d_reg;
    logic [VA_W-1:0]  va_d_reg;
    logic [CNT_W-1:0] pair_rd_reg;
    logic [CNT_W-1:0] val_rd_reg;

    logic             pair_we;
    logic [PA_W-1:0]  pair_wa;
    logic [CNT_W-1:0] pair_wd;
    logic             val_we;
    logic [VA_W-1:0]  val_wa;
    logic [CNT_W-1:0] val_wd;

    // increment is written back the cycle after its read
    always_comb
    begin
        pair_we = inc_d_reg | cmd.pair_clr;
        pair_wa = inc_d_reg ? pa_d_reg : pair_addr;
        pair_wd = inc_d_reg ? pair_rd_reg + CNT_W'(1) : '0;
        val_we  = inc_d_reg | cmd.val_clr;
        val_wa  = inc_d_reg ? va_d_reg : val_addr;
        val_wd  = inc_d_reg ? val_rd_reg + CNT_W'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_d_reg <= 1'b0;
        end
        else
        begin
            inc_d_reg <= cmd.inc;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_d_reg <= pair_addr;
        va_d_reg <= val_addr;
        if (cmd.inc || cmd.pair_clr)
        begin
            pair_rd_reg <= pair_mem[pair_addr];
        end
        if (pair_we)
        begin
            pair_mem[pair_wa] <= pair_wd;
        end
        if (cmd.inc || cmd.val_clr)
        begin
            val_rd_reg <= val_mem[val_addr];
        end
        if (val_we)
        begin
            val_mem[val_wa] <= val_wd;
        end
    end

    assign pair_rd = pair_rd_reg;
    assign val_rd  = val_rd_reg;

endmodule

/* hw/rtl/esfs_log2.sv */
module esfs_log2
    import esfs_pkg::*;
#(
    parameter int CNT_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] n,
    output logic             done,
    output logic [LOG_W-1:0] result
);

    logic [4:0]  k_init;
    logic [30:0] m_init;
    logic [4:0]  k_reg;
    logic [30:0] m_reg;
    logic [15:0] frac_reg;
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [61:0] sq;
    logic [31:0] t;
    logic [30:0] m_next;

    always_comb
    begin
        k_init = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (n[i])
            begin
                k_init = 5'(i);
            end
        end
        m_init = 31'(n) << (5'd30 - k_init);
    end

    // Q2.30 mantissa squared, one fraction bit per cycle
    assign sq     = m_reg * m_reg;
    assign t      = sq[61:30];
    assign m_next = t[31] ? t[31:1] : t[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 4'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'd15;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= k_init;
            m_reg <= m_init;
        end
        else if (busy_reg)
        begin
            m_reg              <= m_next;
            frac_reg[step_reg] <= t[31];
        end
    end

    assign done   = done_reg;
    assign result = {k_reg, frac_reg};

endmodule

/* hw/rtl/esfs_div.sv */
module esfs_div
#(
    parameter int NUM_W = 35,
    parameter int DEN_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CN_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CN_W-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den};
        qbit  = (trial >= {1'b0, den});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CN_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CN_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CN_W'(1);
                if (cnt_reg == CN_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* hw/rtl/entropy_split_feature_select.sv */
// Split selector: streams one feature column at a time and reports its
// conditional class entropy (bits, unsigned Q.16) plus the best column so far.
// Input channel sample: one sample per transfer, valid/stall handshake.
// Output channel result: one transfer per column, on its closing sample.
// A counted sample stalls the next in S_UPD (histogram memory read, then
// write-back); a dropped sample that does not close the column does not.
// Column end walks the value memory and each present value's pair cells,
// reading and clearing each entry; a present value adds its log2 (16
// squaring steps) and a read of each class cell; a non-empty pair cell adds
// its log2, multiply and accumulate; then the divider runs. The walk, the
// log2 unit and the divider set the column-end latency.
// After reset a clearing pass over all NUM_VALUES*NUM_CLASSES pair cells
// (256 at default sizes) and the value cells holds sample_stall high.
// The result sits in an output register; samples of the next column are
// taken while it waits. If result_stall holds it and the next column closes,
// the block waits with sample_stall high until the register frees.
module entropy_split_feature_select
    import esfs_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int NUM_VALUES = 32,
    parameter int NUM_CLASSES = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CELLS = NUM_VALUES * NUM_CLASSES;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int PA_W = $clog2(CELLS);
    localparam int VA_W = $clog2(NUM_VALUES);
    localparam int VC_W = $clog2(NUM_VALUES + 1);
    localparam int CC_W = $clog2(NUM_CLASSES + 1);
    localparam int IC_W = $clog2(CELLS + 1);
    localparam int PRD_W = CNT_W + LOG_W;
    localparam int SUM_W = PRD_W + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] total_reg;
    logic             ovf_reg;
    logic [ENT_W-1:0] min_reg;
    logic             min_valid_reg;
    logic [7:0]       best_id_reg;
    logic [7:0]       best_pos_reg;
    logic [7:0]       col_reg;
    logic [7:0]       fid_reg;
    logic             lastf_reg;
    logic             ls_reg;
    logic [VC_W-1:0]  v_reg;
    logic [CC_W-1:0]  c_reg;
    logic [IC_W-1:0]  init_reg;
    logic [LOG_W-1:0] lv_reg;
    logic [CNT_W-1:0] nvc_reg;
    logic [LOG_W-1:0] diff_reg;
    logic [PRD_W-1:0] prod_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [ENT_W-1:0] h_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    hist_cmd_t        cmd;
    logic [PA_W-1:0]  pair_addr;
    logic [VA_W-1:0]  val_addr;
    logic [CNT_W-1:0] pair_rd;
    logic [CNT_W-1:0] val_rd;
    logic             log_start;
    logic             log_done;
    logic [CNT_W-1:0] log_n;
    logic [LOG_W-1:0] log_res;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_num;
    logic [SUM_W-1:0] div_quo;

    logic acc;
    logic in_range;
    logic count_ok;
    logic doinc;
    logic val_end;
    logic cell_end;
    logic cell_next;
    logic walk_done;
    logic out_free;
    logic take_new;

    always_comb
    begin
        acc       = sample_valid && (state_reg == S_IDLE);
        in_range  = (int'(sample.attr_value) < NUM_VALUES)
                    && (int'(sample.class_label) < NUM_CLASSES);
        count_ok  = total_reg < CNT_W'(MAX_SAMPLES);
        doinc     = acc && count_ok && in_range;
        val_end   = v_reg == VC_W'(NUM_VALUES - 1);
        cell_end  = c_reg == CC_W'(NUM_CLASSES - 1);
        // a pair cell is finished: empty, or its term just accumulated
        cell_next = ((state_reg == S_PWT) && (pair_rd == '0)) || (state_reg == S_ACC);
        walk_done = ((state_reg == S_VWT) && (val_rd == '0) && val_end)
                    || (cell_next && cell_end && val_end);
        out_free  = !out_valid_reg || !result_stall;
        take_new  = !min_valid_reg || (h_reg < min_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_reg == IC_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    priority if (doinc)
                    begin
                        state_next = S_UPD;
                    end
                    else if (sample.last_sample)
                    begin
                        state_next = S_VRD;
                    end
                end
            end
            S_UPD:
            begin
                state_next = ls_reg ? S_VRD : S_IDLE;
            end
            S_VRD:
            begin
                state_next = S_VWT;
            end
            S_VWT:
            begin
                priority if (val_rd != '0)
                begin
                    state_next = S_VLOG;
                end
                else if (val_end)
                begin
                    state_next = (total_reg == '0) ? S_OUT : S_DIV;
                end
                else
                begin
                    state_next = S_VRD;
                end
            end
            S_VLOG:
            begin
                if (log_done)
                begin
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PWT;
            end
            S_PWT, S_ACC:
            begin
                priority if ((state_reg == S_PWT) && (pair_rd != '0))
                begin
                    state_next = S_PLOG;
                end
                else if (!cell_end)
                begin
                    state_next = S_PRD;
                end
                else if (!val_end)
                begin
                    state_next = S_VRD;
                end
                else
                begin
                    state_next = (total_reg == '0) ? S_OUT : S_DIV;
                end
            end
            S_PLOG:
            begin
                if (log_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        pair_addr    = '0;
        val_addr     = '0;
        sample_stall = (state_reg != S_IDLE);
        log_start    = ((state_reg == S_VWT) && (val_rd != '0))
                       || ((state_reg == S_PWT) && (pair_rd != '0));
        log_n        = (state_reg == S_VWT) ? val_rd : pair_rd;
        div_start    = walk_done && (total_reg != '0);
        unique case (state_reg)
            S_INIT:
            begin
                cmd.pair_clr = 1'b1;
                cmd.val_clr  = int'(init_reg) < NUM_VALUES;
                pair_addr    = init_reg[PA_W-1:0];
                val_addr     = init_reg[VA_W-1:0];
            end
            S_IDLE:
            begin
                cmd.inc   = doinc;
                pair_addr = PA_W'(int'(sample.attr_value) * NUM_CLASSES
                                  + int'(sample.class_label));
                val_addr  = VA_W'(int'(sample.attr_value));
            end
            S_VRD:
            begin
                cmd.val_clr = 1'b1;
                val_addr    = v_reg[VA_W-1:0];
            end
            S_PRD:
            begin
                cmd.pair_clr = 1'b1;
                pair_addr    = PA_W'(int'(v_reg) * NUM_CLASSES + int'(c_reg));
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // the last term is still on its way into sum_reg when the walk ends in S_ACC
    assign div_num = sum_reg + SUM_W'(total_reg >> 1)
                     + ((state_reg == S_ACC) ? SUM_W'(prod_reg) : SUM_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            min_valid_reg <= 1'b0;
            min_reg       <= '0;
            best_id_reg   <= '0;
            best_pos_reg  <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INIT)
            begin
                init_reg <= init_reg + IC_W'(1);
            end
            if (acc)
            begin
                if (!count_ok)
                begin
                    ovf_reg <= 1'b1;
                end
                if (doinc)
                begin
                    total_reg <= total_reg + CNT_W'(1);
                end
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= '0;
                ovf_reg       <= 1'b0;
                if (take_new)
                begin
                    min_reg      <= h_reg;
                    best_id_reg  <= fid_reg;
                    best_pos_reg <= col_reg;
                end
                if (lastf_reg)
                begin
                    min_valid_reg <= 1'b0;
                    col_reg       <= '0;
                end
                else
                begin
                    min_valid_reg <= 1'b1;
                    col_reg       <= col_reg + 8'd1;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ls_reg  <= sample.last_sample;
            v_reg   <= '0;
            c_reg   <= '0;
            sum_reg <= '0;
            if (sample.last_sample)
            begin
                fid_reg   <= sample.feature_id;
                lastf_reg <= sample.last_feature;
            end
        end
        if ((state_reg == S_VWT) && (val_rd == '0) && !val_end)
        begin
            v_reg <= v_reg + VC_W'(1);
        end
        if (state_reg == S_VLOG)
        begin
            c_reg <= '0;
            if (log_done)
            begin
                lv_reg <= log_res;
            end
        end
        if (state_reg == S_PWT)
        begin
            nvc_reg <= pair_rd;
        end
        if (cell_next)
        begin
            if (!cell_end)
            begin
                c_reg <= c_reg + CC_W'(1);
            end
            else if (!val_end)
            begin
                v_reg <= v_reg + VC_W'(1);
            end
        end
        if ((state_reg == S_PLOG) && log_done)
        begin
            diff_reg <= lv_reg - log_res;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= nvc_reg * diff_reg;
        end
        if (state_reg == S_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
        if (walk_done && (total_reg == '0))
        begin
            h_reg <= '0;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            h_reg <= (div_quo > SUM_W'(ENT_MAX)) ? ENT_MAX : div_quo[ENT_W-1:0];
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_reg.column_entropy  <= h_reg;
            out_reg.best_feature_id <= take_new ? fid_reg : best_id_reg;
            out_reg.best_position   <= take_new ? col_reg : best_pos_reg;
            out_reg.best_entropy    <= take_new ? h_reg : min_reg;
            out_reg.selection_done  <= lastf_reg;
            out_reg.overflow        <= ovf_reg;
        end
    end

    esfs_hist #(
        .CNT_W(CNT_W),
        .PA_W(PA_W),
        .VA_W(VA_W),
        .CELLS(CELLS),
        .NVALS(NUM_VALUES)
    ) u_hist (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .pair_addr(pair_addr),
        .val_addr(val_addr),
        .pair_rd(pair_rd),
        .val_rd(val_rd)
    );

    esfs_log2 #(
        .CNT_W(CNT_W)
    ) u_log2 (
        .clk(clk),
        .rst_n(rst_n),
        .start(log_start),
        .n(log_n),
        .done(log_done),
        .result(log_res)
    );

    esfs_div #(
        .NUM_W(SUM_W),
        .DEN_W(CNT_W)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(div_num),
        .den(total_reg),
        .done(div_done),
        .quo(div_quo)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hw/rtl/esfs_checker.sv */
module esfs_checker
    import esfs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_stall,
    input sample_t sample,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_best_le_col: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.best_entropy <= result.column_entropy)
        else $error("best entropy above column entropy");

    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample.last_sample |=> sample_stall)
        else $error("column close did not start the walk");

endmodule

bind entropy_split_feature_select esfs_checker u_esfs_checker (.*);

/* bench/entropy_split_feature_select_tb.sv */
`timescale 1ns / 1ps

module entropy_split_feature_select_tb;
    import esfs_pkg::*;

    localparam int MAX_SAMPLES = 4096;
    localparam int NUM_VALUES = 32;
    localparam int NUM_CLASSES = 8;
    localparam int CELLS = NUM_VALUES * NUM_CLASSES;

    // split-entropy predictor with its own histogram copy
    class split_scoreboard;
        int unsigned pair_cnt[CELLS];
        int unsigned val_cnt[NUM_VALUES];
        int unsigned total;
        bit          dropped;
        logic [17:0] min_ent;
        bit          min_ok;
        logic [7:0]  best_id;
        logic [7:0]  best_pos;
        logic [7:0]  col_pos;
        result_t     pending_results[$];
        int          fail_count;
        int          columns_seen;
        int          overflow_columns;

        function void clear_column();
            foreach (pair_cnt[i]) pair_cnt[i] = 0;
            foreach (val_cnt[i]) val_cnt[i] = 0;
            total = 0;
            dropped = 0;
        endfunction

        function void reset_state();
            clear_column();
            min_ent = '0;
            min_ok = 0;
            best_id = '0;
            best_pos = '0;
            col_pos = '0;
        endfunction

        function longint unsigned log2_q16(int unsigned n);
            int unsigned k;
            longint unsigned m;
            longint unsigned frac;
            k = 0;
            frac = 0;
            if (n == 0)
                return 0;
            while (k < 31 && (n >> (k + 1)) != 0)
                k++;
            m = longint'(n) << (30 - k);
            for (int i = 15; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    frac |= 64'd1 << i;
                end
            end
            return (longint'(k) << 16) | frac;
        endfunction

        function logic [17:0] column_entropy();
            longint unsigned sum;
            longint unsigned lv;
            longint unsigned lc;
            longint unsigned h;
            sum = 0;
            if (total == 0)
                return '0;
            for (int v = 0; v < NUM_VALUES; v++)
            begin
                if (val_cnt[v] == 0)
                    continue;
                lv = log2_q16(val_cnt[v]);
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (pair_cnt[v * NUM_CLASSES + c] == 0)
                        continue;
                    lc = log2_q16(pair_cnt[v * NUM_CLASSES + c]);
                    if (lv > lc)
                        sum += longint'(pair_cnt[v * NUM_CLASSES + c]) * (lv - lc);
                end
            end
            h = (sum + total / 2) / total;
            if (h > 64'h3FFFF)
                h = 64'h3FFFF;
            return h[17:0];
        endfunction

        function void note_sample(sample_t s);
            result_t r;
            logic [17:0] h;
            if (total >= MAX_SAMPLES)
                dropped = 1;
            else
            begin
                pair_cnt[s.attr_value * NUM_CLASSES + s.class_label]++;
                val_cnt[s.attr_value]++;
                total++;
            end
            if (!s.last_sample)
                return;
            h = column_entropy();
            if (!min_ok || h < min_ent)
            begin
                min_ent = h;
                min_ok = 1;
                best_id = s.feature_id;
                best_pos = col_pos;
            end
            r.column_entropy = h;
            r.best_feature_id = best_id;
            r.best_position = best_pos;
            r.best_entropy = min_ent;
            r.selection_done = s.last_feature;
            r.overflow = dropped;
            pending_results.insert(pending_results.size(), r);
            columns_seen++;
            if (dropped)
                overflow_columns++;
            clear_column();
            if (s.last_feature)
            begin
                min_ok = 0;
                col_pos = '0;
            end
            else
                col_pos = col_pos + 8'd1;
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no column pending");
                fail_count++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.column_entropy !== exp.column_entropy)
            begin
                $error("column_entropy exp %0d got %0d", exp.column_entropy, got.column_entropy);
                fail_count++;
            end
            if (got.best_feature_id !== exp.best_feature_id)
            begin
                $error("best_feature_id exp %0d got %0d", exp.best_feature_id,
                       got.best_feature_id);
                fail_count++;
            end
            if (got.best_position !== exp.best_position)
            begin
                $error("best_position exp %0d got %0d", exp.best_position, got.best_position);
                fail_count++;
            end
            if (got.best_entropy !== exp.best_entropy)
            begin
                $error("best_entropy exp %0d got %0d", exp.best_entropy, got.best_entropy);
                fail_count++;
            end
            if (got.selection_done !== exp.selection_done)
            begin
                $error("selection_done exp %0d got %0d", exp.selection_done,
                       got.selection_done);
                fail_count++;
            end
            if (got.overflow !== exp.overflow)
            begin
                $error("overflow exp %0d got %0d", exp.overflow, got.overflow);
                fail_count++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    split_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int samples_sent;

    entropy_split_feature_select #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .NUM_VALUES(NUM_VALUES),
        .NUM_CLASSES(NUM_CLASSES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // drive one sample and hold it until the transfer
    task automatic send_sample(sample_t s);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic send_column(logic [7:0] fid, int n, int nvals, int ncls, bit lastf);
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            s.feature_id = (i == n - 1) ? fid : 8'($urandom);
            s.attr_value = 5'($urandom_range(nvals - 1, 0));
            s.class_label = 3'($urandom_range(ncls - 1, 0));
            s.last_sample = (i == n - 1);
            s.last_feature = (i == n - 1) ? lastf : 1'($urandom);
            send_sample(s);
        end
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // results are sampled at the edge; stall is redrawn there
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b1;
        else
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            result_stall <= hold_off ||
                            (recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        sample_t s;
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        samples_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-sample column, all other fields zero
        s = '0;
        s.last_sample = 1'b1;
        send_sample(s);
        // extremes of value/class, id 255, last_feature
        s.feature_id = 8'hFF;
        s.attr_value = 5'd31;
        s.class_label = 3'd7;
        s.last_sample = 1'b0;
        s.last_feature = 1'b1;
        send_sample(s);
        s.class_label = 3'd0;
        send_sample(s);
        s.last_sample = 1'b1;
        send_sample(s);
        // pure column (entropy zero) then a tie, earlier column must hold
        send_column(8'd10, 4, 1, 1, 1'b0);
        send_column(8'd11, 4, 1, 1, 1'b0);
        // max-entropy shaped column: one value, all classes
        for (int c = 0; c < 8; c++)
        begin
            s.feature_id = 8'd12;
            s.attr_value = 5'd3;
            s.class_label = 3'(c);
            s.last_sample = (c == 7);
            s.last_feature = (c == 7);
            send_sample(s);
        end
        wait_drained();

        // overflow column: more than MAX_SAMPLES samples
        send_column(8'd20, MAX_SAMPLES + 3, 32, 8, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 15 : 0;
            for (int col = 0; col < 60; col++)
            begin
                int n;
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
                send_column(8'($urandom), n, $urandom_range(32, 1), $urandom_range(8, 1),
                            ($urandom_range(4, 0) == 0));
                if (phase == 2 && col == 20)
                    wait_drained();
            end
            if (phase == 1)
            begin
                // long receiver hold-off while columns keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (int col = 0; col < 6; col++)
                        send_column(8'(col), 3, 4, 4, 1'b0);
                join
            end
        end
        wait_drained();
        recv_idle_pct = 0;
        repeat (200) @(posedge clk);

        $display("%0d samples over %0d columns (%0d overflowing), idle mixes and hold-off.",
                 samples_sent, sb.columns_seen, sb.overflow_columns);
        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
